// ===== hdl/weighted_random_stream_dequeue_unit_assert.svh =====
// Assertion macros for the weighted random stream dequeue unit.
`ifndef WEIGHTED_RANDOM_STREAM_DEQUEUE_UNIT_ASSERT_SVH
`define WEIGHTED_RANDOM_STREAM_DEQUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define WRSDQ_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wrsdq assertion failed");
`define WRSDQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("wrsdq assertion failed");
`else
`define WRSDQ_ASSERT(name, clk, rst, prop)
`define WRSDQ_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== hdl/wrsdq_pkg.sv =====
package wrsdq_pkg;

  localparam int SID_W       = 4;
  localparam int NUM_STREAMS = 1 << SID_W;
  localparam int SLOT_W      = 7;
  localparam int CAPACITY    = 1 << SLOT_W;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int ADDR_W      = SID_W + SLOT_W;
  localparam int TAG_W       = 32;
  localparam int RND_W       = 16;
  localparam int DEPTH_W     = 8;
  localparam int PROD_W      = RND_W + CNT_W;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(100);
  localparam logic               KIND_PUSH   = 1'b0;
  localparam logic               KIND_DRAIN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_MUL,
    ST_SCAN,
    ST_READ,
    ST_LOAD
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic in_ready;
    logic use_sid;
    logic do_write;
    logic do_mul;
    logic scan_step;
    logic do_read;
    logic load_out;
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic accept;
    logic drain;
    logic full;
    logic empty;
    logic rel_due;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/wrsdq_if.sv =====
interface wrsdq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [wrsdq_pkg::SID_W-1:0]     stream_id;
  logic [wrsdq_pkg::TAG_W-1:0]     event_tag;
  logic [wrsdq_pkg::RND_W-1:0]     random_word;

  modport source (output valid, kind, stream_id, event_tag, random_word, input ready);
  modport sink (input valid, kind, stream_id, event_tag, random_word, output ready);
endinterface

interface wrsdq_out_if;
  logic                            valid;
  logic                            ready;
  logic [wrsdq_pkg::SID_W-1:0]     out_stream;
  logic [wrsdq_pkg::TAG_W-1:0]     out_event;
  logic [wrsdq_pkg::CNT_W-1:0]     remaining;

  modport source (output valid, out_stream, out_event, remaining, input ready);
  modport sink (input valid, out_stream, out_event, remaining, output ready);
endinterface

interface wrsdq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wrsdq_pkg::DEPTH_W-1:0]   delay_depth;

  modport source (output valid, delay_depth, input ready);
  modport sink (input valid, delay_depth, output ready);
endinterface

// ===== hdl/wrsdq_ram.sv =====
module wrsdq_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/wrsdq_ctrl.sv =====
module wrsdq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  wrsdq_pkg::sts_t    sts,
  output wrsdq_pkg::ctl_t    ctl
);

  wrsdq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrsdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wrsdq_pkg::ST_IDLE: begin
        if (sts.accept) begin
          state_next = sts.drain ? wrsdq_pkg::ST_MUL : wrsdq_pkg::ST_PUSH;
        end
      end
      wrsdq_pkg::ST_PUSH: begin
        // a full buffer releases without storing
        if (sts.full || sts.rel_due) begin
          state_next = wrsdq_pkg::ST_MUL;
        end else begin
          state_next = wrsdq_pkg::ST_IDLE;
        end
      end
      wrsdq_pkg::ST_MUL: begin
        state_next = sts.empty ? wrsdq_pkg::ST_IDLE : wrsdq_pkg::ST_SCAN;
      end
      wrsdq_pkg::ST_SCAN: begin
        if (sts.hit) begin
          state_next = wrsdq_pkg::ST_READ;
        end
      end
      wrsdq_pkg::ST_READ: begin
        state_next = wrsdq_pkg::ST_LOAD;
      end
      wrsdq_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          state_next = wrsdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wrsdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      wrsdq_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
      end
      wrsdq_pkg::ST_PUSH: begin
        ctl.use_sid  = 1'b1;
        ctl.do_write = !sts.full;
      end
      wrsdq_pkg::ST_MUL: begin
        ctl.do_mul = 1'b1;
      end
      wrsdq_pkg::ST_SCAN: begin
        ctl.scan_step = 1'b1;
      end
      wrsdq_pkg::ST_READ: begin
        ctl.do_read = 1'b1;
      end
      wrsdq_pkg::ST_LOAD: begin
        ctl.load_out = sts.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// ===== hdl/weighted_random_stream_dequeue_unit.sv =====
// Delay buffer that holds event handles in 16 per-stream FIFOs (128 events in all) and releases
// the oldest event of a stream chosen at random, weighted by its buffered count, whenever a push
// brings the buffered total up to delay_depth, or on each drain request while anything is
// buffered. The block takes one request at a time and is not ready while it works. A push that
// releases nothing stores and goes back to idle, and a drain with nothing buffered goes from the
// multiply step back to idle. A drain that releases runs the multiply, scan steps over the
// streams up to the chosen one, the memory read and the result load, then goes back to idle; a
// push that releases passes through the store step first. The scan through the stream counts
// uses one shared adder and comparator. A finished result sits in an output register, so the
// next request is taken while it waits; a second release stalls in its load step until the first
// is taken. delay_depth is taken at any time outside reset with ready held high; 0 acts as 1 and
// values above 128 act as 128.
`include "weighted_random_stream_dequeue_unit_assert.svh"

module weighted_random_stream_dequeue_unit (
  input logic          clk,
  input logic          rst,
  wrsdq_in_if.sink     in_ch,
  wrsdq_out_if.source  out_ch,
  wrsdq_cfg_if.sink    cfg_ch
);

  localparam int SID_W   = wrsdq_pkg::SID_W;
  localparam int SLOT_W  = wrsdq_pkg::SLOT_W;
  localparam int CNT_W   = wrsdq_pkg::CNT_W;
  localparam int DEPTH_W = wrsdq_pkg::DEPTH_W;
  localparam int PROD_W  = wrsdq_pkg::PROD_W;
  localparam int NS      = wrsdq_pkg::NUM_STREAMS;
  localparam int RND_OFS = wrsdq_pkg::RND_W;

  wrsdq_pkg::ctl_t ctl;
  wrsdq_pkg::sts_t sts;

  logic [DEPTH_W-1:0]  delay_depth;
  logic [DEPTH_W-1:0]  eff_depth;

  logic [SID_W-1:0]    sid;
  logic [wrsdq_pkg::TAG_W-1:0] tag;
  logic [wrsdq_pkg::RND_W-1:0] rnd;

  logic [SLOT_W-1:0]   head [NS];
  logic [CNT_W-1:0]    cnt  [NS];
  logic [CNT_W-1:0]    total;

  logic [CNT_W-1:0]    pick;
  logic [CNT_W-1:0]    acc;
  logic [SID_W-1:0]    idx;

  logic [SID_W-1:0]    tbl_idx;
  logic [CNT_W-1:0]    cnt_rd;
  logic [SLOT_W-1:0]   head_rd;
  logic [CNT_W:0]      sum;
  logic [CNT_W:0]      total_inc;
  logic [PROD_W-1:0]   prod;
  logic [SLOT_W-1:0]   wr_slot;
  logic [wrsdq_pkg::TAG_W-1:0] rdata;

  logic                out_valid;
  logic [SID_W-1:0]    out_stream;
  logic [wrsdq_pkg::TAG_W-1:0] out_event;
  logic [CNT_W-1:0]    remaining;

  // configuration
  assign cfg_ch.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_depth <= wrsdq_pkg::DEPTH_RESET;
    end else if (cfg_ch.valid) begin
      delay_depth <= cfg_ch.delay_depth;
    end
  end

  always_comb begin
    if (delay_depth == '0) begin
      eff_depth = DEPTH_W'(1);
    end else if ({1'b0, delay_depth} > (DEPTH_W+1)'(wrsdq_pkg::CAPACITY)) begin
      eff_depth = DEPTH_W'(wrsdq_pkg::CAPACITY);
    end else begin
      eff_depth = delay_depth;
    end
  end

  // request capture
  assign in_ch.ready = ctl.in_ready && !rst;

  always_ff @(posedge clk) begin
    if (sts.accept) begin
      sid  <= in_ch.stream_id;
      tag  <= in_ch.event_tag;
      rnd  <= in_ch.random_word;
    end
  end

  // stream tables, one read address per cycle
  assign tbl_idx   = ctl.use_sid ? sid : idx;
  assign cnt_rd    = cnt[tbl_idx];
  assign head_rd   = head[tbl_idx];
  assign wr_slot   = head_rd + cnt_rd[SLOT_W-1:0];
  assign sum       = {1'b0, acc} + {1'b0, cnt_rd};
  assign total_inc = {1'b0, total} + (CNT_W+1)'(1);
  assign prod      = PROD_W'(rnd) * PROD_W'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
      total <= '0;
    end else if (ctl.do_write) begin
      cnt[tbl_idx] <= cnt_rd + CNT_W'(1);
      total        <= total_inc[CNT_W-1:0];
    end else if (ctl.do_read) begin
      head[tbl_idx] <= head_rd + SLOT_W'(1);
      cnt[tbl_idx]  <= cnt_rd - CNT_W'(1);
      total         <= total - CNT_W'(1);
    end
  end

  // shared accumulate and compare unit: walk the cumulative counts
  always_ff @(posedge clk) begin
    if (ctl.do_mul) begin
      pick <= prod[PROD_W-1:RND_OFS];
      acc  <= '0;
      idx  <= '0;
    end else if (ctl.scan_step && !sts.hit) begin
      acc <= sum[CNT_W-1:0];
      idx <= idx + SID_W'(1);
    end
  end

  wrsdq_ram #(
    .ADDR_W (wrsdq_pkg::ADDR_W),
    .DATA_W (wrsdq_pkg::TAG_W)
  ) u_store (
    .clk   (clk),
    .we    (ctl.do_write),
    .waddr ({sid, wr_slot}),
    .wdata (tag),
    .re    (ctl.do_read),
    .raddr ({tbl_idx, head_rd}),
    .rdata (rdata)
  );

  assign sts.accept   = in_ch.valid && in_ch.ready;
  assign sts.drain    = (in_ch.kind == wrsdq_pkg::KIND_DRAIN);
  assign sts.full     = (total == CNT_W'(wrsdq_pkg::CAPACITY));
  assign sts.empty    = (total == '0);
  assign sts.rel_due  = (total_inc >= {1'b0, eff_depth});
  assign sts.hit      = ({1'b0, pick} < sum);
  assign sts.out_free = !out_valid || out_ch.ready;

  wrsdq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_stream <= idx;
      out_event  <= rdata;
      remaining  <= total;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_stream = out_stream;
  assign out_ch.out_event  = out_event;
  assign out_ch.remaining  = remaining;

  `WRSDQ_ASSERT(a_out_from_load, clk, rst, $rose(out_valid) |-> $past(ctl.load_out))
  `WRSDQ_ASSERT(a_read_nonempty, clk, rst, ctl.do_read |-> (total != '0) && (cnt_rd != '0))
  `WRSDQ_ASSERT(a_write_room, clk, rst, ctl.do_write |-> cnt_rd < CNT_W'(wrsdq_pkg::CAPACITY))
  `WRSDQ_ASSERT(a_read_dec, clk, rst, ctl.do_read |=> total == $past(total) - CNT_W'(1))

endmodule
